/* hdl/ccfp_pkg.sv */
package ccfp_pkg;

    // Output field width and the fixed widths of the radius datapath.
    localparam int OUT_BITS  = 48;
    localparam int MAG_BITS  = 48;
    localparam int HALF_BITS = 24;
    localparam int SQR_BITS  = 96;
    localparam int SUM_BITS  = 98;
    localparam int ROOT_BITS = 49;
    localparam int REM_BITS  = 51;

    localparam logic [OUT_BITS-1:0] LIM_POS = 48'h7FFF_FFFF_FFFF;
    localparam logic [OUT_BITS-1:0] LIM_NEG = 48'h8000_0000_0000;

    typedef struct packed {
        logic valid;
        logic coll;
        logic sat;
    } ccfp_flags_t;

endpackage

/* hdl/ccfp_front.sv */
module ccfp_front
    import ccfp_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16,
    localparam int NMW = 3 * COORD_BITS + 5 + FRAC_BITS,
    localparam int DTW = 2 * COORD_BITS + 5
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         valid,
    input  logic signed [COORD_BITS-1:0] x1,
    input  logic signed [COORD_BITS-1:0] y1,
    input  logic signed [COORD_BITS-1:0] x2,
    input  logic signed [COORD_BITS-1:0] y2,
    input  logic signed [COORD_BITS-1:0] x3,
    input  logic signed [COORD_BITS-1:0] y3,
    output ccfp_flags_t                  fl,
    output logic signed [COORD_BITS-1:0] px,
    output logic signed [COORD_BITS-1:0] py,
    output logic [NMW-1:0]               nxm,
    output logic [NMW-1:0]               nym,
    output logic                         neg_x,
    output logic                         neg_y,
    output logic [DTW-1:0]               dm
);

    localparam int DW1 = COORD_BITS + 1;
    localparam int AW  = COORD_BITS + 2;
    localparam int SW  = 2 * COORD_BITS;
    localparam int KW  = 2 * COORD_BITS + 2;
    localparam int PRW = 2 * AW;
    localparam int PW  = KW + AW;
    localparam int NXW = PW + 1;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // Stage 1: edge vectors and coordinate squares.
    logic signed [DW1-1:0] d21x, d21y, d31x, d31y;
    logic signed [SW-1:0]  sx1, sy1, sx2, sy2, sx3, sy3;
    logic signed [AW-1:0]  a1_reg, b1_reg, c1_reg, d1_reg;
    logic signed [SW-1:0]  sx1_reg, sy1_reg, sx2_reg, sy2_reg, sx3_reg, sy3_reg;
    logic signed [COORD_BITS-1:0] px1_reg, py1_reg;

    assign d21x = DW1'(x2) - DW1'(x1);
    assign d21y = DW1'(y2) - DW1'(y1);
    assign d31x = DW1'(x3) - DW1'(x1);
    assign d31y = DW1'(y3) - DW1'(y1);
    assign sx1  = x1 * x1;
    assign sy1  = y1 * y1;
    assign sx2  = x2 * x2;
    assign sy2  = y2 * y2;
    assign sx3  = x3 * x3;
    assign sy3  = y3 * y3;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg  <= signed'({d21x, 1'b0});
            b1_reg  <= signed'({d21y, 1'b0});
            c1_reg  <= signed'({d31x, 1'b0});
            d1_reg  <= signed'({d31y, 1'b0});
            sx1_reg <= sx1;
            sy1_reg <= sy1;
            sx2_reg <= sx2;
            sy2_reg <= sy2;
            sx3_reg <= sx3;
            sy3_reg <= sy3;
            px1_reg <= x1;
            py1_reg <= y1;
        end
    end

    // Stage 2: determinant products and squared-norm differences.
    logic signed [PRW-1:0] ad_next, bc_next;
    logic signed [KW-1:0]  k1_next, k2_next;
    logic signed [PRW-1:0] ad_reg, bc_reg;
    logic signed [KW-1:0]  k1_reg, k2_reg;
    logic signed [AW-1:0]  a2_reg, b2_reg, c2_reg, d2_reg;
    logic signed [COORD_BITS-1:0] px2_reg, py2_reg;

    assign ad_next = a1_reg * d1_reg;
    assign bc_next = b1_reg * c1_reg;
    assign k1_next = KW'(sx2_reg) + KW'(sy2_reg) - KW'(sx1_reg) - KW'(sy1_reg);
    assign k2_next = KW'(sx3_reg) + KW'(sy3_reg) - KW'(sx1_reg) - KW'(sy1_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ad_reg  <= ad_next;
            bc_reg  <= bc_next;
            k1_reg  <= k1_next;
            k2_reg  <= k2_next;
            a2_reg  <= a1_reg;
            b2_reg  <= b1_reg;
            c2_reg  <= c1_reg;
            d2_reg  <= d1_reg;
            px2_reg <= px1_reg;
            py2_reg <= py1_reg;
        end
    end

    // Stage 3: determinant and the four Cramer products.
    logic signed [DTW-1:0] det_next;
    logic signed [PW-1:0]  p1_next, p2_next, p3_next, p4_next;
    logic signed [DTW-1:0] det3_reg;
    logic signed [PW-1:0]  p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [COORD_BITS-1:0] px3_reg, py3_reg;

    assign det_next = DTW'(ad_reg) - DTW'(bc_reg);
    assign p1_next  = k1_reg * d2_reg;
    assign p2_next  = k2_reg * b2_reg;
    assign p3_next  = a2_reg * k2_reg;
    assign p4_next  = c2_reg * k1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det3_reg <= det_next;
            p1_reg   <= p1_next;
            p2_reg   <= p2_next;
            p3_reg   <= p3_next;
            p4_reg   <= p4_next;
            px3_reg  <= px2_reg;
            py3_reg  <= py2_reg;
        end
    end

    // Stage 4: numerators.
    logic signed [NXW-1:0] nx_next, ny_next;
    logic signed [NXW-1:0] nx_reg, ny_reg;
    logic signed [DTW-1:0] det4_reg;
    logic signed [COORD_BITS-1:0] px4_reg, py4_reg;

    assign nx_next = NXW'(p1_reg) - NXW'(p2_reg);
    assign ny_next = NXW'(p3_reg) - NXW'(p4_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg   <= nx_next;
            ny_reg   <= ny_next;
            det4_reg <= det3_reg;
            px4_reg  <= px3_reg;
            py4_reg  <= py3_reg;
        end
    end

    // Stage 5: magnitudes and quotient signs; the numerators gain the fraction bits.
    logic [NXW-1:0] nxa, nya;
    logic [DTW-1:0] dma;
    logic [NMW-1:0] nxm_reg, nym_reg;
    logic [DTW-1:0] dm_reg;
    logic           negx_reg, negy_reg, coll_reg;
    logic signed [COORD_BITS-1:0] px5_reg, py5_reg;

    assign nxa = nx_reg[NXW-1] ? NXW'(-nx_reg) : NXW'(nx_reg);
    assign nya = ny_reg[NXW-1] ? NXW'(-ny_reg) : NXW'(ny_reg);
    assign dma = det4_reg[DTW-1] ? DTW'(-det4_reg) : DTW'(det4_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nxm_reg  <= NMW'(nxa) << FRAC_BITS;
            nym_reg  <= NMW'(nya) << FRAC_BITS;
            dm_reg   <= dma;
            negx_reg <= nx_reg[NXW-1] ^ det4_reg[DTW-1];
            negy_reg <= ny_reg[NXW-1] ^ det4_reg[DTW-1];
            coll_reg <= (det4_reg == '0);
            px5_reg  <= px4_reg;
            py5_reg  <= py4_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    assign fl.valid = v5_reg;
    assign fl.coll  = coll_reg;
    assign fl.sat   = 1'b0;
    assign px       = px5_reg;
    assign py       = py5_reg;
    assign nxm      = nxm_reg;
    assign nym      = nym_reg;
    assign neg_x    = negx_reg;
    assign neg_y    = negy_reg;
    assign dm       = dm_reg;

endmodule

/* hdl/ccfp_div.sv */
module ccfp_div
    import ccfp_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16,
    localparam int NMW = 3 * COORD_BITS + 5 + FRAC_BITS,
    localparam int DTW = 2 * COORD_BITS + 5
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  ccfp_flags_t                  fl,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    input  logic [NMW-1:0]               nxm,
    input  logic [NMW-1:0]               nym,
    input  logic                         neg_x,
    input  logic                         neg_y,
    input  logic [DTW-1:0]               dm,
    output ccfp_flags_t                  res_fl,
    output logic signed [COORD_BITS-1:0] base_x,
    output logic signed [COORD_BITS-1:0] base_y,
    output logic signed [OUT_BITS-1:0]   cx,
    output logic signed [OUT_BITS-1:0]   cy
);

    localparam int HIW  = (NMW > OUT_BITS) ? NMW - OUT_BITS : 1;
    localparam int NUMW = OUT_BITS + HIW;
    localparam int CW   = (HIW > DTW) ? HIW : DTW;

    // Both lanes share the divisor. Each stage retires one quotient bit per lane;
    // the quotient shifts in where the numerator bits shift out.
    logic [DTW-1:0]      rx_reg  [0:OUT_BITS];
    logic [DTW-1:0]      ry_reg  [0:OUT_BITS];
    logic [OUT_BITS-1:0] nqx_reg [0:OUT_BITS];
    logic [OUT_BITS-1:0] nqy_reg [0:OUT_BITS];
    logic [DTW-1:0]      dm_reg  [0:OUT_BITS];
    logic                negx_reg [0:OUT_BITS];
    logic                negy_reg [0:OUT_BITS];
    logic                ovfx_reg [0:OUT_BITS];
    logic                ovfy_reg [0:OUT_BITS];
    logic signed [COORD_BITS-1:0] px_reg [0:OUT_BITS];
    logic signed [COORD_BITS-1:0] py_reg [0:OUT_BITS];
    ccfp_flags_t         fl_reg  [0:OUT_BITS];

    // The quotient cannot fit when the bits above the result width already reach the divisor.
    logic [NUMW-1:0] numx, numy;
    logic [HIW-1:0]  hix, hiy;

    assign numx = NUMW'(nxm);
    assign numy = NUMW'(nym);
    assign hix  = numx[NUMW-1:OUT_BITS];
    assign hiy  = numy[NUMW-1:OUT_BITS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg[0]   <= DTW'(hix);
            ry_reg[0]   <= DTW'(hiy);
            nqx_reg[0]  <= numx[OUT_BITS-1:0];
            nqy_reg[0]  <= numy[OUT_BITS-1:0];
            dm_reg[0]   <= dm;
            negx_reg[0] <= neg_x;
            negy_reg[0] <= neg_y;
            ovfx_reg[0] <= (CW'(hix) >= CW'(dm));
            ovfy_reg[0] <= (CW'(hiy) >= CW'(dm));
            px_reg[0]   <= px;
            py_reg[0]   <= py;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fl_reg[0] <= '0;
        end
        else if (en)
        begin
            fl_reg[0] <= fl;
        end
    end

    for (genvar k = 0; k < OUT_BITS; k++)
    begin : g_step
        logic [DTW:0] tx, ty;
        logic         gex, gey;

        assign tx  = {rx_reg[k], nqx_reg[k][OUT_BITS-1]};
        assign ty  = {ry_reg[k], nqy_reg[k][OUT_BITS-1]};
        assign gex = (tx >= {1'b0, dm_reg[k]});
        assign gey = (ty >= {1'b0, dm_reg[k]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rx_reg[k+1]   <= gex ? DTW'(tx - {1'b0, dm_reg[k]}) : DTW'(tx);
                ry_reg[k+1]   <= gey ? DTW'(ty - {1'b0, dm_reg[k]}) : DTW'(ty);
                nqx_reg[k+1]  <= {nqx_reg[k][OUT_BITS-2:0], gex};
                nqy_reg[k+1]  <= {nqy_reg[k][OUT_BITS-2:0], gey};
                dm_reg[k+1]   <= dm_reg[k];
                negx_reg[k+1] <= negx_reg[k];
                negy_reg[k+1] <= negy_reg[k];
                ovfx_reg[k+1] <= ovfx_reg[k];
                ovfy_reg[k+1] <= ovfy_reg[k];
                px_reg[k+1]   <= px_reg[k];
                py_reg[k+1]   <= py_reg[k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                fl_reg[k+1] <= '0;
            end
            else if (en)
            begin
                fl_reg[k+1] <= fl_reg[k];
            end
        end
    end

    // Clip the magnitude (one further step is allowed for a negative result), then apply sign.
    logic [OUT_BITS-1:0]        qx, qy, limx, limy, magx, magy;
    logic                       satx, saty;
    logic signed [OUT_BITS-1:0] cx_next, cy_next;
    logic signed [OUT_BITS-1:0] cx_reg, cy_reg;
    logic signed [COORD_BITS-1:0] bx_reg, by_reg;
    ccfp_flags_t                fl_next, fo_reg;

    assign qx   = nqx_reg[OUT_BITS];
    assign qy   = nqy_reg[OUT_BITS];
    assign limx = negx_reg[OUT_BITS] ? LIM_NEG : LIM_POS;
    assign limy = negy_reg[OUT_BITS] ? LIM_NEG : LIM_POS;
    assign satx = ovfx_reg[OUT_BITS] || (qx > limx);
    assign saty = ovfy_reg[OUT_BITS] || (qy > limy);
    assign magx = satx ? limx : qx;
    assign magy = saty ? limy : qy;
    assign cx_next = negx_reg[OUT_BITS] ? signed'(-magx) : signed'(magx);
    assign cy_next = negy_reg[OUT_BITS] ? signed'(-magy) : signed'(magy);

    always_comb
    begin
        fl_next     = fl_reg[OUT_BITS];
        fl_next.sat = satx | saty;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            bx_reg <= px_reg[OUT_BITS];
            by_reg <= py_reg[OUT_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fo_reg <= '0;
        end
        else if (en)
        begin
            fo_reg <= fl_next;
        end
    end

    assign res_fl = fo_reg;
    assign base_x = bx_reg;
    assign base_y = by_reg;
    assign cx     = cx_reg;
    assign cy     = cy_reg;

endmodule

/* hdl/ccfp_rad.sv */
module ccfp_rad
    import ccfp_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  ccfp_flags_t                  fl,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    input  logic signed [OUT_BITS-1:0]   cx,
    input  logic signed [OUT_BITS-1:0]   cy,
    output logic                         res_valid,
    output logic signed [OUT_BITS-1:0]   res_cx,
    output logic signed [OUT_BITS-1:0]   res_cy,
    output logic [OUT_BITS-1:0]          res_rad,
    output logic                         res_coll,
    output logic                         res_sat
);

    localparam int DXW = OUT_BITS + 2;
    localparam int TW  = REM_BITS + 2;

    ccfp_flags_t fl0_reg, fl1_reg, fl2_reg, fl3_reg;

    // R0: offsets from the first point in fixed point.
    logic signed [DXW-1:0] dx_next, dy_next, dx_reg, dy_reg;
    logic signed [OUT_BITS-1:0] cx0_reg, cy0_reg;

    assign dx_next = DXW'(cx) - (DXW'(px) <<< FRAC_BITS);
    assign dy_next = DXW'(cy) - (DXW'(py) <<< FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            cx0_reg <= cx;
            cy0_reg <= cy;
        end
    end

    // R1: magnitudes, which always stay below 2^48.
    logic [MAG_BITS-1:0] mx_reg, my_reg;
    logic signed [OUT_BITS-1:0] cx1_reg, cy1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg  <= dx_reg[DXW-1] ? MAG_BITS'(-dx_reg) : MAG_BITS'(dx_reg);
            my_reg  <= dy_reg[DXW-1] ? MAG_BITS'(-dy_reg) : MAG_BITS'(dy_reg);
            cx1_reg <= cx0_reg;
            cy1_reg <= cy0_reg;
        end
    end

    // R2: squares split into half-width partial products.
    logic [MAG_BITS-1:0] hhx_reg, hlx_reg, llx_reg, hhy_reg, hly_reg, lly_reg;
    logic signed [OUT_BITS-1:0] cx2_reg, cy2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hhx_reg <= mx_reg[MAG_BITS-1:HALF_BITS] * mx_reg[MAG_BITS-1:HALF_BITS];
            hlx_reg <= mx_reg[MAG_BITS-1:HALF_BITS] * mx_reg[HALF_BITS-1:0];
            llx_reg <= mx_reg[HALF_BITS-1:0] * mx_reg[HALF_BITS-1:0];
            hhy_reg <= my_reg[MAG_BITS-1:HALF_BITS] * my_reg[MAG_BITS-1:HALF_BITS];
            hly_reg <= my_reg[MAG_BITS-1:HALF_BITS] * my_reg[HALF_BITS-1:0];
            lly_reg <= my_reg[HALF_BITS-1:0] * my_reg[HALF_BITS-1:0];
            cx2_reg <= cx1_reg;
            cy2_reg <= cy1_reg;
        end
    end

    // R3: recombine; the cross term appears twice, hence one extra bit of shift.
    logic [SQR_BITS-1:0] sqx_reg, sqy_reg;
    logic signed [OUT_BITS-1:0] cx3_reg, cy3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg <= (SQR_BITS'(hhx_reg) << MAG_BITS)
                     + (SQR_BITS'(hlx_reg) << (HALF_BITS + 1)) + SQR_BITS'(llx_reg);
            sqy_reg <= (SQR_BITS'(hhy_reg) << MAG_BITS)
                     + (SQR_BITS'(hly_reg) << (HALF_BITS + 1)) + SQR_BITS'(lly_reg);
            cx3_reg <= cx2_reg;
            cy3_reg <= cy2_reg;
        end
    end

    // R4 and the root stages: one root bit per stage, two radicand bits consumed.
    logic [REM_BITS-1:0]  rem_reg  [0:ROOT_BITS];
    logic [ROOT_BITS-1:0] root_reg [0:ROOT_BITS];
    logic [SUM_BITS-1:0]  sr_reg   [0:ROOT_BITS];
    logic signed [OUT_BITS-1:0] rcx_reg [0:ROOT_BITS];
    logic signed [OUT_BITS-1:0] rcy_reg [0:ROOT_BITS];
    ccfp_flags_t          rfl_reg  [0:ROOT_BITS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            sr_reg[0]   <= SUM_BITS'(sqx_reg) + SUM_BITS'(sqy_reg);
            rcx_reg[0]  <= cx3_reg;
            rcy_reg[0]  <= cy3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fl0_reg    <= '0;
            fl1_reg    <= '0;
            fl2_reg    <= '0;
            fl3_reg    <= '0;
            rfl_reg[0] <= '0;
        end
        else if (en)
        begin
            fl0_reg    <= fl;
            fl1_reg    <= fl0_reg;
            fl2_reg    <= fl1_reg;
            fl3_reg    <= fl2_reg;
            rfl_reg[0] <= fl3_reg;
        end
    end

    for (genvar k = 0; k < ROOT_BITS; k++)
    begin : g_root
        logic [TW-1:0] t, trial;
        logic          ge;

        assign t     = {rem_reg[k], sr_reg[k][SUM_BITS-1 -: 2]};
        assign trial = TW'({root_reg[k], 2'b01});
        assign ge    = (t >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= ge ? REM_BITS'(t - trial) : REM_BITS'(t);
                root_reg[k+1] <= {root_reg[k][ROOT_BITS-2:0], ge};
                sr_reg[k+1]   <= sr_reg[k] << 2;
                rcx_reg[k+1]  <= rcx_reg[k];
                rcy_reg[k+1]  <= rcy_reg[k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rfl_reg[k+1] <= '0;
            end
            else if (en)
            begin
                rfl_reg[k+1] <= rfl_reg[k];
            end
        end
    end

    // Output register: radius clip; a collinear triple zeroes centre, radius and sat.
    logic [ROOT_BITS-1:0] root;
    logic                 satr;
    logic [OUT_BITS-1:0]  rad_next;
    ccfp_flags_t          flf;
    logic                 v_reg, coll_reg, sat_reg;
    logic signed [OUT_BITS-1:0] ocx_reg, ocy_reg;
    logic [OUT_BITS-1:0]  orad_reg;

    assign root     = root_reg[ROOT_BITS];
    assign satr     = root[ROOT_BITS-1];
    assign rad_next = satr ? '1 : root[OUT_BITS-1:0];
    assign flf      = rfl_reg[ROOT_BITS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ocx_reg  <= flf.coll ? '0 : rcx_reg[ROOT_BITS];
            ocy_reg  <= flf.coll ? '0 : rcy_reg[ROOT_BITS];
            orad_reg <= flf.coll ? '0 : rad_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= 1'b0;
            coll_reg <= 1'b0;
            sat_reg  <= 1'b0;
        end
        else if (en)
        begin
            v_reg    <= flf.valid;
            coll_reg <= flf.coll;
            sat_reg  <= !flf.coll && (flf.sat || satr);
        end
    end

    assign res_valid = v_reg;
    assign res_cx    = ocx_reg;
    assign res_cy    = ocy_reg;
    assign res_rad   = orad_reg;
    assign res_coll  = coll_reg;
    assign res_sat   = sat_reg;

endmodule

/* hdl/circumcircle_from_three_points.sv */
// Stages from an accepted point triple to its circle on the output: 5 front-end stages,
// 50 divider stages (an entry register, 48 quotient-bit stages and the clip register) and
// 55 radius stages (4 offset and squaring stages, an entry register, 49 root-bit stages
// and the output register). Throughput: one transaction per cycle while no result stalls.
// The whole pipeline advances together; it holds only while a result waits stalled.
// Reset (rst_n, asynchronous, active low) clears every valid bit; data is not reset.
module circumcircle_from_three_points
    import ccfp_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         pt_valid,
    output logic                         pt_stall,
    input  logic signed [COORD_BITS-1:0] x1,
    input  logic signed [COORD_BITS-1:0] y1,
    input  logic signed [COORD_BITS-1:0] x2,
    input  logic signed [COORD_BITS-1:0] y2,
    input  logic signed [COORD_BITS-1:0] x3,
    input  logic signed [COORD_BITS-1:0] y3,
    output logic                         circ_valid,
    input  logic                         circ_stall,
    output logic signed [OUT_BITS-1:0]   center_x,
    output logic signed [OUT_BITS-1:0]   center_y,
    output logic [OUT_BITS-1:0]          radius,
    output logic                         collinear,
    output logic                         saturated
);

    localparam int NMW = 3 * COORD_BITS + 5 + FRAC_BITS;
    localparam int DTW = 2 * COORD_BITS + 5;

    logic en;

    ccfp_flags_t                  fe_fl, dv_fl;
    logic signed [COORD_BITS-1:0] fe_px, fe_py, dv_px, dv_py;
    logic [NMW-1:0]               fe_nxm, fe_nym;
    logic                         fe_negx, fe_negy;
    logic [DTW-1:0]               fe_dm;
    logic signed [OUT_BITS-1:0]   dv_cx, dv_cy;

    assign en       = !(circ_valid && circ_stall);
    assign pt_stall = !en;

    ccfp_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .valid (pt_valid),
        .x1    (x1),
        .y1    (y1),
        .x2    (x2),
        .y2    (y2),
        .x3    (x3),
        .y3    (y3),
        .fl    (fe_fl),
        .px    (fe_px),
        .py    (fe_py),
        .nxm   (fe_nxm),
        .nym   (fe_nym),
        .neg_x (fe_negx),
        .neg_y (fe_negy),
        .dm    (fe_dm)
    );

    ccfp_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .fl     (fe_fl),
        .px     (fe_px),
        .py     (fe_py),
        .nxm    (fe_nxm),
        .nym    (fe_nym),
        .neg_x  (fe_negx),
        .neg_y  (fe_negy),
        .dm     (fe_dm),
        .res_fl (dv_fl),
        .base_x (dv_px),
        .base_y (dv_py),
        .cx     (dv_cx),
        .cy     (dv_cy)
    );

    ccfp_rad #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_rad (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .fl        (dv_fl),
        .px        (dv_px),
        .py        (dv_py),
        .cx        (dv_cx),
        .cy        (dv_cy),
        .res_valid (circ_valid),
        .res_cx    (center_x),
        .res_cy    (center_y),
        .res_rad   (radius),
        .res_coll  (collinear),
        .res_sat   (saturated)
    );

    a_coll_zero: assert property (@(posedge clk) disable iff (!rst_n)
        circ_valid && collinear |->
            center_x == '0 && center_y == '0 && radius == '0 && !saturated)
        else $error("collinear result carries non-zero fields");

    a_sat_not_coll: assert property (@(posedge clk) disable iff (!rst_n)
        circ_valid && saturated |-> !collinear)
        else $error("saturation flagged on a collinear result");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        circ_valid && circ_stall |=> circ_valid && $stable(radius))
        else $error("stalled result lost or changed");

    a_frozen_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        pt_stall |-> circ_valid && circ_stall)
        else $error("input stalled while the pipeline could advance");

endmodule
